[rtl/core/rplc_pkg.sv]
// Shared constants and helpers for the raw pixel line packer.
// Holds mode, byte kind and register index codes and the CRC-16 byte update.
// No dependencies.
package rplc_pkg;

	// packing modes
	localparam logic [2:0] MODE_RAW8   = 3'd0;
	localparam logic [2:0] MODE_RAW10  = 3'd1;
	localparam logic [2:0] MODE_RAW12  = 3'd2;
	localparam logic [2:0] MODE_RAW14  = 3'd3;
	localparam logic [2:0] MODE_YUV422 = 3'd4;

	// byte kinds on the output stream
	localparam logic [1:0] KIND_HDR = 2'd0;
	localparam logic [1:0] KIND_PAY = 2'd1;
	localparam logic [1:0] KIND_CRC = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_PIXEL_MODE  = 2'd0;
	localparam logic [1:0] REG_FORMAT_CODE = 2'd1;
	localparam logic [1:0] REG_LINE_WIDTH  = 2'd2;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	// number of byte slots one pixel can produce
	localparam int SLOTS = 8;

	// reflected crc-16, polynomial 0x8408, one byte in closed form
	function automatic logic [15:0] crc_upd(input logic [15:0] crc, input logic [7:0] b);
		logic [7:0] x;
		x = crc[7:0] ^ b;
		x = x ^ {x[3:0], 4'b0000};
		crc_upd = {x, crc[15:8]} ^ {12'h000, x[7:4]} ^ {5'b00000, x, 3'b000};
	endfunction

endpackage

[rtl/core/raw_pixel_line_packer_crc16.sv]
// Raw pixel line packer with per-line CRC-16, top level.
// Uses rplc_pkg for codes and the CRC byte update.
//
// Usage:
// Pixels enter on in_valid/in_ready with pixel, one per request. Packed
// bytes leave on out_valid/out_ready with out_byte, byte_kind, line_end
// and last, one byte per request. Registers are written on
// cfg_valid/cfg_ready (cfg_index, cfg_data); cfg_ready is always high and
// writes are meant for idle periods only.
// A pixel is taken into an input register, and once the result register is
// free all the bytes it causes (header, payload, crc, up to eight) are formed
// at once into that register, which is drained one byte per cycle while
// out_ready is high. The first byte is shown as soon as it is loaded.
// Throughput is set by the single-byte output port: a pixel holds it for
// as many bytes as it makes, at least one, so raw8 makes 1 byte per
// pixel, raw10 1.25 on average, raw12 1.5, raw14 1.75 and yuv422 2, plus
// 4 header bytes at each line start and 2 crc bytes at each line end. The next
// pixel is taken while the current result is still being drained.
// Reset clears the registers to mode raw8, format code 0, width 1, and
// starts a new line. When out_ready is low the shown byte holds and the
// input register fills and then drops in_ready.
module raw_pixel_line_packer_crc16
	import rplc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// pixel input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] pixel,
	// byte output
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic [1:0]  byte_kind,
	output logic        line_end,
	output logic        last
);

	// configuration registers
	logic [2:0]  mode_q;
	logic [7:0]  fmt_q;
	logic [15:0] width_q;

	// derived line geometry
	logic [16:0] aligned_q;
	logic [15:0] bpl_q;
	logic [16:0] aligned_d;
	logic [18:0] bpl_d;
	logic [16:0] w_ext;

	// line state
	logic [15:0] pixel_index_q;
	logic [15:0] crc_q;
	logic [7:0]  residual_q;

	// input register
	logic [15:0] pix_s1;
	logic        vld_s1;

	// result register
	logic [7:0]  slot_byte_q [SLOTS];
	logic [1:0]  slot_kind_q [SLOTS];
	logic [3:0]  cnt_q;
	logic [2:0]  idx_q;
	logic        out_vld_q;

	// stage logic
	logic [2:0]  mode_n;
	logic [1:0]  pos;
	logic        hdr;
	logic        line_done;
	logic [7:0]  p0;
	logic [7:0]  p1;
	logic [3:0]  npay;
	logic [7:0]  residual_d;
	logic [15:0] crc_start;
	logic [15:0] crc_c1;
	logic [15:0] crc_c2;
	logic [3:0]  pay_start;
	logic [3:0]  pay_end;
	logic [3:0]  cnt_d;
	logic [7:0]  hdr_byte [4];
	logic [7:0]  slot_byte_d [SLOTS];
	logic [1:0]  slot_kind_d [SLOTS];
	logic [3:0]  jj;

	logic out_last;
	logic res_free;
	logic adv;

	// configuration write port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_RAW8;
			fmt_q   <= 8'h00;
			width_q <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PIXEL_MODE:  mode_q  <= cfg_data[2:0];
				REG_FORMAT_CODE: fmt_q   <= cfg_data[7:0];
				REG_LINE_WIDTH:  width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// unknown modes behave as raw8
	assign mode_n = (mode_q <= MODE_YUV422) ? mode_q : MODE_RAW8;

	// rounded width and bytes per line
	always_comb begin
		w_ext = (width_q == 16'd0) ? 17'd1 : {1'b0, width_q};
		case (mode_n)
			MODE_RAW10, MODE_RAW14: aligned_d = (w_ext + 17'd3) & ~17'd3;
			MODE_RAW12:             aligned_d = (w_ext + 17'd1) & ~17'd1;
			default:                aligned_d = w_ext;
		endcase
		case (mode_n)
			MODE_RAW10:  bpl_d = {2'b00, aligned_d} + {4'b0000, aligned_d[16:2]};
			MODE_RAW12:  bpl_d = {2'b00, aligned_d} + {3'b000, aligned_d[16:1]};
			MODE_RAW14:  bpl_d = {2'b00, aligned_d} + {3'b000, aligned_d[16:1]}
			                     + {4'b0000, aligned_d[16:2]};
			MODE_YUV422: bpl_d = {1'b0, aligned_d, 1'b0};
			default:     bpl_d = {2'b00, aligned_d};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aligned_q <= 17'd1;
			bpl_q     <= 16'd1;
		end else begin
			aligned_q <= aligned_d;
			bpl_q     <= bpl_d[15:0];
		end
	end

	// handshake between input register and result register
	assign out_last = ({1'b0, idx_q} == (cnt_q - 4'd1));
	assign res_free = !out_vld_q || (out_ready && out_last);
	assign adv      = vld_s1 && res_free;
	assign in_ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pix_s1 <= pixel;
		end
	end

	// group position and line boundaries
	always_comb begin
		case (mode_n)
			MODE_RAW10, MODE_RAW14: pos = pixel_index_q[1:0];
			MODE_RAW12:             pos = {1'b0, pixel_index_q[0]};
			default:                pos = 2'd0;
		endcase
		hdr       = (pixel_index_q == 16'd0);
		line_done = (({1'b0, pixel_index_q} + 17'd1) >= aligned_q);
	end

	// payload bytes and residual byte by mode
	always_comb begin
		p0         = pix_s1[7:0];
		p1         = 8'h00;
		npay       = 4'd1;
		residual_d = residual_q;
		unique case (mode_n)
			MODE_RAW10: begin
				p0 = pix_s1[9:2];
				if (pos == 2'd0) begin
					residual_d = {6'b000000, pix_s1[1:0]};
				end else begin
					residual_d = residual_q | ({6'b000000, pix_s1[1:0]} << {pos, 1'b0});
				end
				p1 = residual_d;
				if (pos == 2'd3) begin
					npay = 4'd2;
				end
			end
			MODE_RAW12: begin
				p0 = pix_s1[11:4];
				if (pos == 2'd0) begin
					residual_d = {4'h0, pix_s1[3:0]};
				end else begin
					residual_d = residual_q | {pix_s1[3:0], 4'h0};
					npay       = 4'd2;
				end
				p1 = residual_d;
			end
			MODE_RAW14: begin
				p0 = pix_s1[13:6];
				case (pos)
					2'd0: begin
						residual_d = {2'b00, pix_s1[5:0]};
					end
					2'd1: begin
						p1         = residual_q | {pix_s1[1:0], 6'b000000};
						residual_d = {4'h0, pix_s1[5:2]};
						npay       = 4'd2;
					end
					2'd2: begin
						p1         = residual_q | {pix_s1[3:0], 4'h0};
						residual_d = {6'b000000, pix_s1[5:4]};
						npay       = 4'd2;
					end
					default: begin
						residual_d = residual_q | {pix_s1[5:0], 2'b00};
						p1         = residual_d;
						npay       = 4'd2;
					end
				endcase
			end
			MODE_YUV422: begin
				p0   = pix_s1[7:0];
				p1   = pix_s1[15:8];
				npay = 4'd2;
			end
			default: begin
				p0 = pix_s1[7:0];
			end
		endcase
	end

	// crc over this pixel's payload
	always_comb begin
		crc_start = hdr ? CRC_INIT : crc_q;
		crc_c1    = crc_upd(crc_start, p0);
		crc_c2    = (npay == 4'd2) ? crc_upd(crc_c1, p1) : crc_c1;
	end

	// lay the bytes of this pixel into slots
	always_comb begin
		hdr_byte[0] = fmt_q;
		hdr_byte[1] = bpl_q[7:0];
		hdr_byte[2] = bpl_q[15:8];
		hdr_byte[3] = 8'h00;
		pay_start   = hdr ? 4'd4 : 4'd0;
		pay_end     = pay_start + npay;
		cnt_d       = pay_end + (line_done ? 4'd2 : 4'd0);
		jj          = 4'd0;
		for (int j = 0; j < SLOTS; j++) begin
			jj = 4'(j);
			if (jj < pay_start) begin
				slot_byte_d[j] = hdr_byte[jj[1:0]];
				slot_kind_d[j] = KIND_HDR;
			end else if (jj == pay_start) begin
				slot_byte_d[j] = p0;
				slot_kind_d[j] = KIND_PAY;
			end else if (jj < pay_end) begin
				slot_byte_d[j] = p1;
				slot_kind_d[j] = KIND_PAY;
			end else if (jj == pay_end) begin
				slot_byte_d[j] = crc_c2[7:0];
				slot_kind_d[j] = KIND_CRC;
			end else begin
				slot_byte_d[j] = crc_c2[15:8];
				slot_kind_d[j] = KIND_CRC;
			end
		end
	end

	// line state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_index_q <= 16'd0;
			crc_q         <= CRC_INIT;
			residual_q    <= 8'h00;
		end else if (adv) begin
			if (line_done) begin
				pixel_index_q <= 16'd0;
				crc_q         <= CRC_INIT;
				residual_q    <= 8'h00;
			end else begin
				pixel_index_q <= pixel_index_q + 16'd1;
				crc_q         <= crc_c2;
				residual_q    <= residual_d;
			end
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			cnt_q     <= 4'd0;
			idx_q     <= 3'd0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
			cnt_q     <= cnt_d;
			idx_q     <= 3'd0;
		end else if (out_vld_q && out_ready) begin
			if (out_last) begin
				out_vld_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	// result slots
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < SLOTS; j++) begin
				slot_byte_q[j] <= slot_byte_d[j];
				slot_kind_q[j] <= slot_kind_d[j];
			end
		end
	end

	// byte output
	assign out_valid = out_vld_q;
	assign out_byte  = slot_byte_q[idx_q];
	assign byte_kind = slot_kind_q[idx_q];
	assign last      = out_last;
	assign line_end  = out_last && (slot_kind_q[idx_q] == KIND_CRC);

endmodule
